### hw/rtl/pyaw_pkg.sv
package pyaw_pkg;

  // Normalized magnitudes have their leading one at bit NORM_BITS-1.
  localparam int NORM_BITS = 30;
  // Sum of two squares of normalized values, and the square root remainder.
  localparam int SQ_BITS   = 61;
  localparam int REM_BITS  = 63;
  localparam int ROOT_BITS = 31;
  // CORDIC datapath width and angle accumulator fraction bits (degrees).
  localparam int CW        = 34;
  localparam int ACC_FRAC  = 24;

  typedef logic signed [CW-1:0] cval_t;

  // 90 degrees in accumulator units.
  localparam cval_t QUARTER = cval_t'(64'sd1509949440);

  // atan(2^-i) in degrees with ACC_FRAC fraction bits, rounded to nearest.
  localparam cval_t ATAN_TAB [32] = '{
    cval_t'(754974720), cval_t'(445687602), cval_t'(235489088), cval_t'(119537938),
    cval_t'(60000934),  cval_t'(30029717),  cval_t'(15018523),  cval_t'(7509720),
    cval_t'(3754917),   cval_t'(1877466),   cval_t'(938734),    cval_t'(469367),
    cval_t'(234684),    cval_t'(117342),    cval_t'(58671),     cval_t'(29335),
    cval_t'(14668),     cval_t'(7334),      cval_t'(3667),      cval_t'(1833),
    cval_t'(917),       cval_t'(458),       cval_t'(229),       cval_t'(115),
    cval_t'(57),        cval_t'(29),        cval_t'(14),        cval_t'(7),
    cval_t'(4),         cval_t'(2),         cval_t'(1),         cval_t'(0)
  };

  typedef struct packed {
    cval_t x;
    cval_t y;
    cval_t z;
  } lane_t;

  // Words that ride alongside the square root pipeline.
  typedef struct packed {
    logic signed [NORM_BITS:0] pz;
    lane_t                     yl;
    logic                      yaw_zero;
  } side_t;

  // Words inside the CORDIC pipeline.
  typedef struct packed {
    lane_t pl;
    lane_t yl;
    logic  r_zero;
    logic  pz_pos;
    logic  pz_neg;
    logic  yaw_zero;
  } cstage_t;

endpackage

### hw/rtl/pyaw_if.sv
interface pyaw_in_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] src_x;
  logic signed [COORD_BITS-1:0] src_y;
  logic signed [COORD_BITS-1:0] src_z;
  logic signed [COORD_BITS-1:0] dst_x;
  logic signed [COORD_BITS-1:0] dst_y;
  logic signed [COORD_BITS-1:0] dst_z;

  modport source (output valid, src_x, src_y, src_z, dst_x, dst_y, dst_z, input ready);
  modport sink   (input valid, src_x, src_y, src_z, dst_x, dst_y, dst_z, output ready);
endinterface

interface pyaw_out_if #(
  parameter int ANGLE_FRAC_BITS = 7
);
  logic                              valid;
  logic                              ready;
  logic signed [ANGLE_FRAC_BITS+7:0] pitch;
  logic signed [ANGLE_FRAC_BITS+8:0] yaw;

  modport source (output valid, pitch, yaw, input ready);
  modport sink   (input valid, pitch, yaw, output ready);
endinterface

### hw/rtl/point_pair_to_pitch_yaw.sv
// Pipeline: 5 front stages, 31 square root steps, CORDIC_STAGES iterations and 1 output
//   register lie between the input word and the output word.
// Throughput: one word per cycle while the pipeline is not stalled; every stage is a register with no feedback loop.
// Backpressure stalls the whole pipeline at once while the output word is not taken.
// Reset (synchronous, active low) clears only the valid bits; data registers keep junk.
module point_pair_to_pitch_yaw #(
  parameter int COORD_BITS      = 24,
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_STAGES   = 20
) (
  input logic        clk,
  input logic        rst_n,
  pyaw_in_if.sink    in_ch,
  pyaw_out_if.source out_ch
);

  // Delta magnitudes need one bit more than a coordinate. The normalizer works
  // on a word at least NORM_BITS wide so that small deltas shift left and large
  // ones (wide coordinates) shift right with truncation of the magnitude.
  localparam int MW   = COORD_BITS + 1;
  localparam int NW   = (MW > pyaw_pkg::NORM_BITS) ? MW : pyaw_pkg::NORM_BITS;
  localparam int LZW  = $clog2(NW);
  localparam int NB   = pyaw_pkg::NORM_BITS;
  localparam int PB   = ANGLE_FRAC_BITS + 8;
  localparam int YB   = ANGLE_FRAC_BITS + 9;
  localparam int SH   = pyaw_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int CW   = pyaw_pkg::CW;
  localparam int NSQ  = pyaw_pkg::ROOT_BITS;

  localparam logic signed [CW:0] FULL = (CW+1)'(90) <<< ANGLE_FRAC_BITS;
  localparam logic signed [CW:0] RND  = (CW+1)'(1) <<< (SH - 1);

  // The whole pipeline advances together whenever the output register is free
  // or is being emptied in this cycle.
  logic en;
  logic out_valid_r;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------------------------------------------------------------------
  // Stage 1: the delta source minus destination, one bit wider than a coordinate.
  // ---------------------------------------------------------------------------
  logic                 v1_r;
  logic signed [MW-1:0] dx_r, dy_r, dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= {in_ch.src_x[COORD_BITS-1], in_ch.src_x} - {in_ch.dst_x[COORD_BITS-1], in_ch.dst_x};
      dy_r <= {in_ch.src_y[COORD_BITS-1], in_ch.src_y} - {in_ch.dst_y[COORD_BITS-1], in_ch.dst_y};
      dz_r <= {in_ch.src_z[COORD_BITS-1], in_ch.src_z} - {in_ch.dst_z[COORD_BITS-1], in_ch.dst_z};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: magnitudes, signs and leading zero counts. The leading one of the
  // largest magnitude is the leading one of the OR of all magnitudes, so no
  // compare is needed. Pitch normalizes all three deltas, yaw only dx and dy.
  // ---------------------------------------------------------------------------
  logic [MW-1:0] mx, my, mz;
  logic [NW-1:0] or_p, or_y;
  logic [LZW-1:0] lz_p, lz_y;

  assign mx = dx_r[MW-1] ? MW'(-dx_r) : MW'(dx_r);
  assign my = dy_r[MW-1] ? MW'(-dy_r) : MW'(dy_r);
  assign mz = dz_r[MW-1] ? MW'(-dz_r) : MW'(dz_r);
  assign or_y = NW'(mx | my);
  assign or_p = NW'(mx | my | mz);

  always_comb begin
    lz_p = '0;
    lz_y = '0;
    for (int i = 0; i < NW; i++) begin
      if (or_p[i]) lz_p = LZW'(NW - 1 - i);
      if (or_y[i]) lz_y = LZW'(NW - 1 - i);
    end
  end

  logic           v2_r;
  logic [MW-1:0]  mx_r, my_r, mz_r;
  logic           sx_r, sy_r, sz_r;
  logic [LZW-1:0] lz_p_r, lz_y_r;
  logic           yzero2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r     <= mx;
      my_r     <= my;
      mz_r     <= mz;
      sx_r     <= dx_r[MW-1];
      sy_r     <= dy_r[MW-1];
      sz_r     <= dz_r[MW-1];
      lz_p_r   <= lz_p;
      lz_y_r   <= lz_y;
      yzero2_r <= (or_y == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: normalizing shift. After the shift the leading one of the largest
  // magnitude sits at the top of the word; the top NB bits are kept, which is
  // a left shift for small deltas and a truncating right shift for large ones.
  // ---------------------------------------------------------------------------
  function automatic logic [NB-1:0] norm(input logic [MW-1:0] m, input logic [LZW-1:0] lz);
    logic [NW-1:0] t;
    t = NW'(m) << lz;
    return t[NW-1 -: NB];
  endfunction

  function automatic logic signed [NB:0] apply_sign(input logic [NB-1:0] m, input logic s);
    return s ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  logic                   v3_r;
  logic [NB-1:0]          pxm_r, pym_r;
  logic signed [NB:0]     pz_r, yx_r, yy_r;
  logic                   yzero3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxm_r    <= norm(mx_r, lz_p_r);
      pym_r    <= norm(my_r, lz_p_r);
      pz_r     <= apply_sign(norm(mz_r, lz_p_r), sz_r);
      yx_r     <= apply_sign(norm(mx_r, lz_y_r), sx_r);
      yy_r     <= apply_sign(norm(my_r, lz_y_r), sy_r);
      yzero3_r <= yzero2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: squares of the horizontal components (one 30x30 multiplier each),
  // and the yaw start vector. Yaw is the angle of (-dx, -dy); when that vector
  // points into the left half plane it is first turned by a quarter toward the
  // positive x axis, so the CORDIC always starts with x >= 0.
  // ---------------------------------------------------------------------------
  logic [2*NB-1:0]   sqx_r, sqy_r;
  logic              v4_r;
  pyaw_pkg::side_t   side4_r;
  pyaw_pkg::lane_t   ylane;

  always_comb begin
    if (yx_r > 0) begin
      if (yy_r <= 0) begin
        ylane.x = CW'(-yy_r);
        ylane.y = CW'(yx_r);
        ylane.z = pyaw_pkg::QUARTER;
      end else begin
        ylane.x = CW'(yy_r);
        ylane.y = CW'(-yx_r);
        ylane.z = -pyaw_pkg::QUARTER;
      end
    end else begin
      ylane.x = CW'(-yx_r);
      ylane.y = CW'(-yy_r);
      ylane.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r            <= pxm_r * pxm_r;
      sqy_r            <= pym_r * pym_r;
      side4_r.pz       <= pz_r;
      side4_r.yl       <= ylane;
      side4_r.yaw_zero <= yzero3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: dx^2 + dy^2, which seeds the square root remainder.
  // ---------------------------------------------------------------------------
  logic                            v5_r;
  logic [pyaw_pkg::REM_BITS-1:0]   sum_r;
  pyaw_pkg::side_t                 side5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r   <= pyaw_pkg::REM_BITS'(sqx_r) + pyaw_pkg::REM_BITS'(sqy_r);
      side5_r <= side4_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Square root: one restoring step per stage, most significant root bit first.
  // The result is floor(sqrt(dx^2 + dy^2)), exact.
  // ---------------------------------------------------------------------------
  logic                             sq_v    [0:NSQ];
  logic [pyaw_pkg::REM_BITS-1:0]    sq_rem  [0:NSQ];
  logic [pyaw_pkg::ROOT_BITS-1:0]   sq_root [0:NSQ];
  pyaw_pkg::side_t                  sq_side [0:NSQ];

  assign sq_v[0]    = v5_r;
  assign sq_rem[0]  = sum_r;
  assign sq_root[0] = '0;
  assign sq_side[0] = side5_r;

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    pyaw_sqrt_step #(.BIT(NSQ - 1 - j)) u_step (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (en),
      .in_valid    (sq_v[j]),
      .in_rem      (sq_rem[j]),
      .in_root     (sq_root[j]),
      .in_side     (sq_side[j]),
      .out_valid_r (sq_v[j+1]),
      .out_rem_r   (sq_rem[j+1]),
      .out_root_r  (sq_root[j+1]),
      .out_side_r  (sq_side[j+1])
    );
  end

  // ---------------------------------------------------------------------------
  // CORDIC: pitch from (r, dz) and yaw from the turned vector, side by side.
  // The special-case flags travel with the word and take over at the end.
  // ---------------------------------------------------------------------------
  logic              co_v    [0:CORDIC_STAGES];
  pyaw_pkg::cstage_t co_word [0:CORDIC_STAGES];

  always_comb begin
    co_word[0].pl.x     = CW'(sq_root[NSQ]);
    co_word[0].pl.y     = CW'(sq_side[NSQ].pz);
    co_word[0].pl.z     = '0;
    co_word[0].yl       = sq_side[NSQ].yl;
    co_word[0].r_zero   = (sq_root[NSQ] == '0);
    co_word[0].pz_pos   = (sq_side[NSQ].pz > 0);
    co_word[0].pz_neg   = (sq_side[NSQ].pz < 0);
    co_word[0].yaw_zero = sq_side[NSQ].yaw_zero;
  end
  assign co_v[0] = sq_v[NSQ];

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    pyaw_cordic_step #(.IDX(k)) u_step (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (en),
      .in_valid    (co_v[k]),
      .in_word     (co_word[k]),
      .out_valid_r (co_v[k+1]),
      .out_word_r  (co_word[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output stage: round to the output angle unit, then saturate pitch at the
  // poles and wrap yaw into (-180, 180]. Zero horizontal distance gives pitch
  // from the sign of dz; coincident horizontal position gives yaw 180.
  // ---------------------------------------------------------------------------
  pyaw_pkg::cstage_t      fw;
  logic signed [CW:0]     prnd, yrnd, pfin, yfin;

  assign fw   = co_word[CORDIC_STAGES];
  assign prnd = ($signed({fw.pl.z[CW-1], fw.pl.z}) + RND) >>> SH;
  assign yrnd = ($signed({fw.yl.z[CW-1], fw.yl.z}) + RND) >>> SH;

  always_comb begin
    if (fw.r_zero) begin
      pfin = fw.pz_pos ? FULL : (fw.pz_neg ? -FULL : '0);
    end else if (prnd > FULL) begin
      pfin = FULL;
    end else if (prnd < -FULL) begin
      pfin = -FULL;
    end else begin
      pfin = prnd;
    end

    if (fw.yaw_zero) begin
      yfin = FULL <<< 1;
    end else if (yrnd <= -(FULL <<< 1)) begin
      yfin = yrnd + (FULL <<< 2);
    end else if (yrnd > (FULL <<< 1)) begin
      yfin = yrnd - (FULL <<< 2);
    end else begin
      yfin = yrnd;
    end
  end

  logic signed [PB-1:0] out_pitch_r;
  logic signed [YB-1:0] out_yaw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= co_v[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pitch_r <= pfin[PB-1:0];
      out_yaw_r   <= yfin[YB-1:0];
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.pitch = out_pitch_r;
  assign out_ch.yaw   = out_yaw_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((CW+1)'(out_ch.pitch) <= FULL) && ((CW+1)'(out_ch.pitch) >= -FULL))
    else $error("pitch outside -90..90 degrees");

  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((CW+1)'(out_ch.yaw) > -(FULL <<< 1)))
    else $error("yaw at or below -180 degrees");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v1_r)
    else $error("accepted word did not enter the first stage");

endmodule

### hw/rtl/pyaw_sqrt_step.sv
// One restoring step of the integer square root: decides root bit BIT.
module pyaw_sqrt_step #(
  parameter int BIT = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [pyaw_pkg::REM_BITS-1:0]     in_rem,
  input  logic [pyaw_pkg::ROOT_BITS-1:0]    in_root,
  input  pyaw_pkg::side_t                   in_side,
  output logic                              out_valid_r,
  output logic [pyaw_pkg::REM_BITS-1:0]     out_rem_r,
  output logic [pyaw_pkg::ROOT_BITS-1:0]    out_root_r,
  output pyaw_pkg::side_t                   out_side_r
);

  logic [pyaw_pkg::REM_BITS-1:0]  test;
  logic [pyaw_pkg::REM_BITS-1:0]  rem_nxt;
  logic [pyaw_pkg::ROOT_BITS-1:0] root_nxt;

  // (r + 2^k)^2 - r^2 = r * 2^(k+1) + 2^(2k)
  always_comb begin
    test = ({{(pyaw_pkg::REM_BITS-pyaw_pkg::ROOT_BITS){1'b0}}, in_root} << (BIT + 1))
         + ({{(pyaw_pkg::REM_BITS-1){1'b0}}, 1'b1} << (2 * BIT));
    if (in_rem >= test) begin
      rem_nxt  = in_rem - test;
      root_nxt = in_root | ({{(pyaw_pkg::ROOT_BITS-1){1'b0}}, 1'b1} << BIT);
    end else begin
      rem_nxt  = in_rem;
      root_nxt = in_root;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem_r  <= rem_nxt;
      out_root_r <= root_nxt;
      out_side_r <= in_side;
    end
  end

endmodule

### hw/rtl/pyaw_cordic_step.sv
// One vectoring CORDIC iteration, applied to the pitch and the yaw lane.
module pyaw_cordic_step #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  pyaw_pkg::cstage_t   in_word,
  output logic                out_valid_r,
  output pyaw_pkg::cstage_t   out_word_r
);

  pyaw_pkg::cstage_t word_nxt;

  function automatic pyaw_pkg::lane_t rotate(input pyaw_pkg::lane_t l);
    pyaw_pkg::lane_t o;
    pyaw_pkg::cval_t xs;
    pyaw_pkg::cval_t ys;
    xs = l.x >>> IDX;
    ys = l.y >>> IDX;
    if (l.y >= 0) begin
      o.x = l.x + ys;
      o.y = l.y - xs;
      o.z = l.z + pyaw_pkg::ATAN_TAB[IDX];
    end else begin
      o.x = l.x - ys;
      o.y = l.y + xs;
      o.z = l.z - pyaw_pkg::ATAN_TAB[IDX];
    end
    return o;
  endfunction

  always_comb begin
    word_nxt    = in_word;
    word_nxt.pl = rotate(in_word.pl);
    word_nxt.yl = rotate(in_word.yl);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r <= word_nxt;
    end
  end

endmodule
